>>> hdl/aest_pkg.sv
// Shared constants, types and helpers for the active error set table.
package aest_pkg;

  // Number of code slots in the table.
  localparam int ENTRIES = 10;

  // Slot index width and cursor/count width (count reaches ENTRIES itself).
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  // Field widths of the channels.
  localparam int FUNC_W   = 2;
  localparam int CODE_W   = 8;
  localparam int STATUS_W = 2;
  localparam int VIEW_W   = 4;

  // Byte that marks an empty slot ('#').
  localparam logic [CODE_W-1:0] EMPTY_MARK = 8'd35;

  // Operation codes.
  localparam logic [FUNC_W-1:0] FN_ADD    = 2'd0;
  localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd1;
  localparam logic [FUNC_W-1:0] FN_FETCH  = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NONE = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;   // capture the incoming word, rewind the scan
    logic step;    // examine one slot
    logic commit;  // apply the outcome, load the result register
  } aest_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;    // the current step is the final one of the scan
  } aest_sts_t;

  // Low VIEW_W bits of a cursor or count, zero-extended when narrower.
  function automatic logic [VIEW_W-1:0] to_view(input logic [CNT_W-1:0] v);
    logic [CNT_W+VIEW_W-1:0] w;
    w = {{VIEW_W{1'b0}}, v};
    return w[VIEW_W-1:0];
  endfunction

endpackage

>>> hdl/aest_if.sv
// Valid/ready channel interfaces for the request and result words.
interface aest_in_if
  import aest_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [CODE_W-1:0] code;

  modport source (output valid, output func, output code, input ready);
  modport sink   (input valid, input func, input code, output ready);
endinterface

interface aest_out_if
  import aest_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [CODE_W-1:0]   error_code;
  logic [VIEW_W-1:0]   display_index;
  logic [VIEW_W-1:0]   error_count;

  modport source (output valid, output status, output error_code,
                  output display_index, output error_count, input ready);
  modport sink   (input valid, input status, input error_code,
                  input display_index, input error_count, output ready);
endinterface

>>> hdl/active_error_set_table.sv
// Top level of the active error set table: controller plus datapath.
//
//  Channel  Dir  Word fields                                          Handshake
//  in_if    in   func[1:0] code[7:0]                                  valid/ready
//  out_if   out  status[1:0] error_code[7:0] display_index[3:0]
//                error_count[3:0]                                     valid/ready
//
// One word at a time: accept, then the scan, then commit.
// Add, remove and the unused code walk all ENTRIES slots, one slot per cycle
// through the single table read port. Fetch stops at the first occupied slot
// from the cursor, at the last slot, or when no code is left to show.
// Reset (synchronous, active low) marks every slot empty and clears the
// counters; the block takes a word in the very next cycle.
// A result held by out_ready low does not block the next accept; only the
// commit of the following word waits for the result register to drain.
module active_error_set_table
  import aest_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  aest_in_if.sink    in_if,
  aest_out_if.source out_if
);

  aest_cmd_t cmd;
  aest_sts_t sts;

  // sequencing: accept, scan, commit
  aest_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // slots, counters and the result register
  aest_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_func           (in_if.func),
    .in_code           (in_if.code),
    .res_status        (out_if.status),
    .res_error_code    (out_if.error_code),
    .res_display_index (out_if.display_index),
    .res_error_count   (out_if.error_count)
  );

endmodule

>>> hdl/aest_ctrl.sv
// Sequencer for the error table: accept, scan the slots, commit the result.
module aest_ctrl
  import aest_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  aest_sts_t sts,
  output aest_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_COMMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.step = 1'b1;
        if (sts.last) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        // hold until the result register is free or drains this cycle
        if (!out_valid_r || out_ready) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

>>> hdl/aest_dp.sv
// Slot storage, counters, one-slot-per-cycle scan and the result register.
module aest_dp
  import aest_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  aest_cmd_t           cmd,
  output aest_sts_t           sts,
  input  logic [FUNC_W-1:0]   in_func,
  input  logic [CODE_W-1:0]   in_code,
  output logic [STATUS_W-1:0] res_status,
  output logic [CODE_W-1:0]   res_error_code,
  output logic [VIEW_W-1:0]   res_display_index,
  output logic [VIEW_W-1:0]   res_error_count
);

  logic [CODE_W-1:0] slots_r [ENTRIES];
  logic [CNT_W-1:0]  live_r, cursor_r, shown_r;

  logic [FUNC_W-1:0] func_r;
  logic [CODE_W-1:0] code_r;
  logic [IDX_W-1:0]  idx_r;
  logic              found_r, empty_seen_r, hit_r;
  logic [IDX_W-1:0]  empty_idx_r;
  logic [CODE_W-1:0] got_r;

  logic [STATUS_W-1:0] status_r;
  logic [CODE_W-1:0]   error_code_r;
  logic [VIEW_W-1:0]   display_index_r, error_count_r;

  logic [IDX_W-1:0]    rd_addr;
  logic [CODE_W-1:0]   rd_val;
  logic                fetch_go, idx_last, cur_last, rd_empty;
  logic [CNT_W-1:0]    live_c, cursor_c, shown_c;
  logic [STATUS_W-1:0] status_c;
  logic [CODE_W-1:0]   got_c;
  logic                wr_add;

  // single read port: fetch walks the display cursor, add/remove walk idx
  always_comb begin
    rd_addr  = (func_r == FN_FETCH) ? cursor_r[IDX_W-1:0] : idx_r;
    rd_val   = slots_r[rd_addr];
    rd_empty = (rd_val == EMPTY_MARK);
    idx_last = (idx_r == IDX_W'(ENTRIES - 1));
    cur_last = (cursor_r == CNT_W'(ENTRIES - 1));
    fetch_go = (live_r != '0) && (shown_r < live_r) && (cursor_r < CNT_W'(ENTRIES));
    case (func_r)
      FN_FETCH: sts.last = !fetch_go || !rd_empty || cur_last;
      default:  sts.last = idx_last;
    endcase
  end

  // outcome applied at commit
  always_comb begin
    live_c   = live_r;
    cursor_c = cursor_r;
    shown_c  = shown_r;
    status_c = ST_OK;
    got_c    = '0;
    wr_add   = 1'b0;
    case (func_r)
      FN_ADD: begin
        if (code_r != EMPTY_MARK && !found_r) begin
          if (empty_seen_r) begin
            wr_add = 1'b1;
            live_c = live_r + CNT_W'(1);
          end else begin
            status_c = ST_FULL;
          end
        end
      end
      FN_FETCH: begin
        if (hit_r) begin
          shown_c = shown_r + CNT_W'(1);
          got_c   = got_r;
        end else begin
          cursor_c = '0;
          shown_c  = '0;
          status_c = ST_NONE;
        end
      end
      default: begin
      end
    endcase
  end

  // table state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) begin
        slots_r[i] <= EMPTY_MARK;
      end
      live_r   <= '0;
      cursor_r <= '0;
      shown_r  <= '0;
    end else if (cmd.step) begin
      case (func_r)
        FN_REMOVE: begin
          if (code_r != EMPTY_MARK && rd_val == code_r) begin
            slots_r[idx_r] <= EMPTY_MARK;
            if (live_r != '0) begin
              live_r <= live_r - CNT_W'(1);
            end
          end
        end
        FN_FETCH: begin
          if (fetch_go) begin
            cursor_r <= cursor_r + CNT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end else if (cmd.commit) begin
      if (wr_add) begin
        slots_r[empty_idx_r] <= code_r;
      end
      live_r   <= live_c;
      cursor_r <= cursor_c;
      shown_r  <= shown_c;
    end
  end

  // per-word scan registers and result register
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      func_r       <= in_func;
      code_r       <= in_code;
      idx_r        <= '0;
      found_r      <= 1'b0;
      empty_seen_r <= 1'b0;
      empty_idx_r  <= '0;
      hit_r        <= 1'b0;
      got_r        <= '0;
    end else if (cmd.step) begin
      idx_r <= idx_r + IDX_W'(1);
      if (func_r == FN_ADD) begin
        if (rd_val == code_r) begin
          found_r <= 1'b1;
        end
        if (rd_empty && !empty_seen_r) begin
          empty_seen_r <= 1'b1;
          empty_idx_r  <= idx_r;
        end
      end
      if (func_r == FN_FETCH && fetch_go && !rd_empty) begin
        hit_r <= 1'b1;
        got_r <= rd_val;
      end
    end
    if (cmd.commit) begin
      status_r        <= status_c;
      error_code_r    <= got_c;
      display_index_r <= to_view(cursor_c);
      error_count_r   <= to_view(live_c);
    end
  end

  assign res_status        = status_r;
  assign res_error_code    = error_code_r;
  assign res_display_index = display_index_r;
  assign res_error_count   = error_count_r;

endmodule

>>> hdl/aest_checker.sv
// Port-level assertions for the error table, bound to the top level.
module aest_checker
  import aest_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STATUS_W-1:0] out_status,
  input logic [CODE_W-1:0]   out_error_code,
  input logic [VIEW_W-1:0]   out_display_index
);

  // a stalled result word stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // an accepted word starts a scan, so no second accept right after
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a scan is running");

  // only a delivered fetch carries a code
  a_code_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> out_error_code == '0)
    else $error("error code on a result that is not ok");

  // running out of codes rewinds the display cursor
  a_none_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_NONE) |-> out_display_index == '0)
    else $error("cursor not rewound on no more codes");

endmodule

bind active_error_set_table aest_checker u_aest_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_if.valid),
  .in_ready          (in_if.ready),
  .out_valid         (out_if.valid),
  .out_ready         (out_if.ready),
  .out_status        (out_if.status),
  .out_error_code    (out_if.error_code),
  .out_display_index (out_if.display_index)
);
